// ----- src/thermal_power_step_governor_macros.svh -----
// Assertion macros shared by the thermal power step governor RTL.
`ifndef THERMAL_POWER_STEP_GOVERNOR_MACROS_SVH
`define THERMAL_POWER_STEP_GOVERNOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPSG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpsg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TPSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpsg: next-cycle check failed");

`endif

// ----- src/tpsg_pkg.sv -----
// Types and constants shared by the thermal power step governor modules.
`timescale 1ns / 1ps

package tpsg_pkg;

  localparam int TEMP_W  = 12;
  localparam int PWR_IN_W = 15;
  localparam int PWR_W   = 16;
  localparam int FREQ_W  = 12;
  localparam int FSTEP_W = 11;
  localparam int CUR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HYST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_HYST   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [CUR_W-1:0]   RST_MIN_CURRENT  = 16'd300;
  localparam logic [CUR_W-1:0]   RST_MAX_CURRENT  = 16'd3000;
  localparam logic [CUR_W-1:0]   RST_CURRENT_STEP = 16'd100;
  localparam logic [FSTEP_W-1:0] RST_FREQ_STEP    = 11'd100;
  localparam logic [TEMP_W-1:0]  RST_TEMP_LIMIT   = 12'd1280;
  localparam logic [PWR_W-1:0]   RST_POWER_LIMIT  = 16'd1600;
  localparam logic [TEMP_W-1:0]  RST_TEMP_HYST    = 12'd32;
  localparam logic [PWR_W-1:0]   RST_POWER_HYST   = 16'd80;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_PWR_FAIL  = 2'd1;
  localparam logic [1:0] STAT_TEMP_FAIL = 2'd2;
  localparam logic [1:0] STAT_BOTH_FAIL = 2'd3;

  typedef struct packed {
    logic [CUR_W-1:0]   min_current_ma;
    logic [CUR_W-1:0]   max_current_ma;
    logic [CUR_W-1:0]   current_step_ma;
    logic [FSTEP_W-1:0] freq_step_mhz;
    logic [TEMP_W-1:0]  temp_limit;
    logic [PWR_W-1:0]   power_limit;
    logic [TEMP_W-1:0]  temp_hysteresis;
    logic [PWR_W-1:0]   power_hysteresis;
  } cfg_t;

  // Reduced sample: hottest core and total power.
  typedef struct packed {
    logic [TEMP_W-1:0] tmax;
    logic [PWR_W-1:0]  ptot;
  } sample_t;

endpackage

// ----- src/tpsg_sense.sv -----
// Input stage: picks the hottest core, sums the powers and registers the sample.
`timescale 1ns / 1ps

module tpsg_sense #(
  parameter int CORES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [tpsg_pkg::TEMP_W-1:0]     in_core_temp_0,
  input  logic [tpsg_pkg::TEMP_W-1:0]     in_core_temp_1,
  input  logic [tpsg_pkg::TEMP_W-1:0]     in_core_temp_2,
  input  logic [tpsg_pkg::TEMP_W-1:0]     in_core_temp_3,
  input  logic [tpsg_pkg::PWR_IN_W-1:0]   in_cpu_power,
  input  logic [tpsg_pkg::PWR_IN_W-1:0]   in_cooler_power,
  input  logic                            s_take,
  output logic                            s_valid,
  output tpsg_pkg::sample_t               s_sample
);

  logic [tpsg_pkg::TEMP_W-1:0] temps [4];
  tpsg_pkg::sample_t           sample_nxt;
  tpsg_pkg::sample_t           sample_r;
  logic                        valid_r;
  logic                        valid_nxt;
  logic                        accept;

  assign temps[0] = in_core_temp_0;
  assign temps[1] = in_core_temp_1;
  assign temps[2] = in_core_temp_2;
  assign temps[3] = in_core_temp_3;

  always_comb begin
    sample_nxt.tmax = temps[0];
    for (int k = 1; k < 4; k++) begin
      if (k < CORES && temps[k] > sample_nxt.tmax) begin
        sample_nxt.tmax = temps[k];
      end
    end
    sample_nxt.ptot = {1'b0, in_cpu_power} + {1'b0, in_cooler_power};
  end

  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && !s_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      sample_r <= sample_nxt;
    end
  end

  assign s_valid  = valid_r;
  assign s_sample = sample_r;

endmodule

// ----- src/tpsg_ctrl.sv -----
// Decision stage: region compare, bounded steps, state update and result register.
`timescale 1ns / 1ps

`include "thermal_power_step_governor_macros.svh"

module tpsg_ctrl #(
  parameter int FREQ_MIN_MHZ = 1600,
  parameter int FREQ_MAX_MHZ = 2800
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpsg_pkg::cfg_t                cfg,
  input  logic                          s_valid,
  input  tpsg_pkg::sample_t             s_sample,
  output logic                          s_take,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [tpsg_pkg::FREQ_W-1:0]   out_freq_mhz,
  output logic [tpsg_pkg::CUR_W-1:0]    out_current_ma,
  output logic                          out_freq_changed,
  output logic                          out_current_changed,
  output logic [1:0]                    out_status
);

  localparam logic signed [13:0] FMIN_S = 14'(FREQ_MIN_MHZ);
  localparam logic signed [13:0] FMAX_S = 14'(FREQ_MAX_MHZ);

  logic [tpsg_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic [tpsg_pkg::CUR_W-1:0]  cur_r, cur_nxt;
  logic                        first_r, first_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [tpsg_pkg::FREQ_W-1:0] out_freq_r;
  logic [tpsg_pkg::CUR_W-1:0]  out_cur_r;
  logic                        out_fchg_r, out_cchg_r;
  logic [1:0]                  out_status_r;

  logic signed [13:0] f_up, f_dn;
  logic signed [17:0] c_up, c_dn, cmin_s, cmax_s;
  logic signed [12:0] t_relax;
  logic signed [16:0] p_relax;
  logic [tpsg_pkg::CUR_W-1:0] cur_base;
  logic f_up_ok, f_dn_ok, c_up_ok, c_dn_ok;
  logic t_lt, t_gt, p_lt, p_gt, t_rel, p_rel;
  logic f_chg, c_chg, f_dir_up, c_dir_up, try_c;
  logic [1:0] status;

  always_comb begin
    f_up = $signed({2'b00, freq_r}) + $signed({3'b000, cfg.freq_step_mhz});
    f_dn = $signed({2'b00, freq_r}) - $signed({3'b000, cfg.freq_step_mhz});
    f_up_ok = (f_up >= FMIN_S) && (f_up <= FMAX_S);
    f_dn_ok = (f_dn >= FMIN_S) && (f_dn <= FMAX_S);

    // The first current decision starts from the configured minimum.
    cur_base = first_r ? cfg.min_current_ma : cur_r;
    cmin_s = $signed({2'b00, cfg.min_current_ma});
    cmax_s = $signed({2'b00, cfg.max_current_ma});
    c_up = $signed({2'b00, cur_base}) + $signed({2'b00, cfg.current_step_ma});
    c_dn = $signed({2'b00, cur_base}) - $signed({2'b00, cfg.current_step_ma});
    c_up_ok = (c_up >= cmin_s) && (c_up <= cmax_s);
    c_dn_ok = (c_dn >= cmin_s) && (c_dn <= cmax_s);

    t_lt = s_sample.tmax < cfg.temp_limit;
    t_gt = s_sample.tmax > cfg.temp_limit;
    p_lt = s_sample.ptot < cfg.power_limit;
    p_gt = s_sample.ptot > cfg.power_limit;
    // Relaxed thresholds may go negative, in which case nothing meets them.
    t_relax = $signed({1'b0, cfg.temp_limit}) - $signed({1'b0, cfg.temp_hysteresis});
    p_relax = $signed({1'b0, cfg.power_limit}) - $signed({1'b0, cfg.power_hysteresis});
    t_rel = $signed({1'b0, s_sample.tmax}) < t_relax;
    p_rel = $signed({1'b0, s_sample.ptot}) < p_relax;

    f_chg    = 1'b0;
    c_chg    = 1'b0;
    f_dir_up = 1'b0;
    c_dir_up = 1'b0;
    try_c    = 1'b0;
    status   = tpsg_pkg::STAT_OK;
    if (t_lt && p_lt) begin
      f_dir_up = 1'b1;
      f_chg    = t_rel && p_rel && f_up_ok;
      try_c    = t_rel && !f_chg;
      c_chg    = try_c && c_dn_ok;
    end else if (t_lt && p_gt) begin
      try_c = 1'b1;
      c_chg = c_dn_ok;
      f_chg = !c_chg && f_dn_ok;
      if (!c_chg && !f_chg) begin
        status = tpsg_pkg::STAT_PWR_FAIL;
      end
    end else if (t_gt && p_lt) begin
      c_dir_up = 1'b1;
      try_c    = p_rel;
      c_chg    = try_c && c_up_ok;
      f_chg    = !c_chg && f_dn_ok;
      if (!c_chg && !f_chg) begin
        status = tpsg_pkg::STAT_TEMP_FAIL;
      end
    end else if (t_gt && p_gt) begin
      f_chg = f_dn_ok;
      if (!f_chg) begin
        status = tpsg_pkg::STAT_BOTH_FAIL;
      end
    end

    if (f_chg) begin
      freq_nxt = f_dir_up ? f_up[11:0] : f_dn[11:0];
    end else begin
      freq_nxt = freq_r;
    end
    if (c_chg) begin
      cur_nxt = c_dir_up ? c_up[15:0] : c_dn[15:0];
    end else if (try_c) begin
      cur_nxt = cur_base;
    end else begin
      cur_nxt = cur_r;
    end
    first_nxt = first_r && !try_c;
  end

  // The state loop is registered, so a sample may enter each cycle unless stalled.
  assign s_take        = s_valid && !(out_valid_r && out_stall);
  assign out_valid_nxt = s_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= 12'(FREQ_MIN_MHZ);
      cur_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s_take) begin
        freq_r  <= freq_nxt;
        cur_r   <= cur_nxt;
        first_r <= first_nxt;
      end
    end
    if (s_take) begin
      out_freq_r   <= freq_nxt;
      out_cur_r    <= cur_nxt;
      out_fchg_r   <= f_chg;
      out_cchg_r   <= c_chg;
      out_status_r <= status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_freq_mhz        = out_freq_r;
  assign out_current_ma      = out_cur_r;
  assign out_freq_changed    = out_fchg_r;
  assign out_current_changed = out_cchg_r;
  assign out_status          = out_status_r;

  `TPSG_ASSERT_NOW(a_one_step, clk, rst_n, out_valid_r, !(out_fchg_r && out_cchg_r))
  `TPSG_ASSERT_NOW(a_step_ok, clk, rst_n, out_valid_r && (out_fchg_r || out_cchg_r), out_status_r == tpsg_pkg::STAT_OK)
  `TPSG_ASSERT_NEXT(a_first_once, clk, rst_n, !first_r, !first_r)

endmodule

// ----- src/thermal_power_step_governor.sv -----
// Top level of the thermal power step governor: configuration registers and stages.
`timescale 1ns / 1ps

`include "thermal_power_step_governor_macros.svh"

// Each request carries up to four core temperatures and two power readings and
// yields one registered result; a new request is taken every cycle unless the
// output stalls. The first stage reduces the sample to the hottest core and the
// total power, the second stage compares against the limits, steps frequency or
// cooler current within their bounds and updates both in the same cycle, which sets
// that rate. Status 0: ok, 1 power, 2 temperature, 3 both constraints failed. The
// user writes configuration by cfg_we/cfg_idx/cfg_wdata only while idle, unchecked.
module thermal_power_step_governor #(
  parameter int CORES        = 4,
  parameter int FREQ_MIN_MHZ = 1600,
  parameter int FREQ_MAX_MHZ = 2800
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tpsg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tpsg_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tpsg_pkg::TEMP_W-1:0]        in_core_temp_0,
  input  logic [tpsg_pkg::TEMP_W-1:0]        in_core_temp_1,
  input  logic [tpsg_pkg::TEMP_W-1:0]        in_core_temp_2,
  input  logic [tpsg_pkg::TEMP_W-1:0]        in_core_temp_3,
  input  logic [tpsg_pkg::PWR_IN_W-1:0]      in_cpu_power,
  input  logic [tpsg_pkg::PWR_IN_W-1:0]      in_cooler_power,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tpsg_pkg::FREQ_W-1:0]        out_freq_mhz,
  output logic [tpsg_pkg::CUR_W-1:0]         out_current_ma,
  output logic                               out_freq_changed,
  output logic                               out_current_changed,
  output logic [1:0]                         out_status
);

  tpsg_pkg::cfg_t    cfg_r;
  tpsg_pkg::sample_t s_sample;
  logic              s_valid;
  logic              s_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_current_ma   <= tpsg_pkg::RST_MIN_CURRENT;
      cfg_r.max_current_ma   <= tpsg_pkg::RST_MAX_CURRENT;
      cfg_r.current_step_ma  <= tpsg_pkg::RST_CURRENT_STEP;
      cfg_r.freq_step_mhz    <= tpsg_pkg::RST_FREQ_STEP;
      cfg_r.temp_limit       <= tpsg_pkg::RST_TEMP_LIMIT;
      cfg_r.power_limit      <= tpsg_pkg::RST_POWER_LIMIT;
      cfg_r.temp_hysteresis  <= tpsg_pkg::RST_TEMP_HYST;
      cfg_r.power_hysteresis <= tpsg_pkg::RST_POWER_HYST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tpsg_pkg::CFG_MIN_CURRENT:  cfg_r.min_current_ma   <= cfg_wdata;
        tpsg_pkg::CFG_MAX_CURRENT:  cfg_r.max_current_ma   <= cfg_wdata;
        tpsg_pkg::CFG_CURRENT_STEP: cfg_r.current_step_ma  <= cfg_wdata;
        tpsg_pkg::CFG_FREQ_STEP:    cfg_r.freq_step_mhz    <= cfg_wdata[tpsg_pkg::FSTEP_W-1:0];
        tpsg_pkg::CFG_TEMP_LIMIT:   cfg_r.temp_limit       <= cfg_wdata[tpsg_pkg::TEMP_W-1:0];
        tpsg_pkg::CFG_POWER_LIMIT:  cfg_r.power_limit      <= cfg_wdata;
        tpsg_pkg::CFG_TEMP_HYST:    cfg_r.temp_hysteresis  <= cfg_wdata[tpsg_pkg::TEMP_W-1:0];
        tpsg_pkg::CFG_POWER_HYST:   cfg_r.power_hysteresis <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The input register stalls only when it is full and the result cannot move.
  assign in_stall = s_valid && !s_take;

  tpsg_sense #(
    .CORES(CORES)
  ) u_sense (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_core_temp_0  (in_core_temp_0),
    .in_core_temp_1  (in_core_temp_1),
    .in_core_temp_2  (in_core_temp_2),
    .in_core_temp_3  (in_core_temp_3),
    .in_cpu_power    (in_cpu_power),
    .in_cooler_power (in_cooler_power),
    .s_take          (s_take),
    .s_valid         (s_valid),
    .s_sample        (s_sample)
  );

  tpsg_ctrl #(
    .FREQ_MIN_MHZ(FREQ_MIN_MHZ),
    .FREQ_MAX_MHZ(FREQ_MAX_MHZ)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .s_valid             (s_valid),
    .s_sample            (s_sample),
    .s_take              (s_take),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_freq_mhz        (out_freq_mhz),
    .out_current_ma      (out_current_ma),
    .out_freq_changed    (out_freq_changed),
    .out_current_changed (out_current_changed),
    .out_status          (out_status)
  );

  `TPSG_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, s_valid && out_valid && out_stall)

endmodule
